### rtl/core/rect_outline_fill_raster_defines.svh
// assertion helpers for the rasterizer
`ifndef RECT_OUTLINE_FILL_RASTER_DEFINES_SVH
`define RECT_OUTLINE_FILL_RASTER_DEFINES_SVH

// checked only while out of reset
`define ROFR_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// checked at every edge, reset included
`define ROFR_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/rofr_pkg.sv
package rofr_pkg;

    localparam int IN_TDATA_W  = 128;
    localparam int OUT_TDATA_W = 16;
    localparam int COORD_W     = 24;
    localparam int CHAR_W      = 8;
    localparam int CFG_DATA_W  = 9;
    localparam int CFG_ADDR_W  = 2;

    localparam logic [1:0] FUNC_DRAW  = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;
    localparam logic [1:0] FUNC_NOP   = 2'd3;

    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BG_CHAR      = 2'd2;

    localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RST  = 9'd256;
    localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RST = 9'd256;
    localparam logic [CHAR_W-1:0]     BG_CHAR_RST      = 8'd32;

    typedef struct packed {
        logic in_span;
        logic border;
    } hit_t;

endpackage

### rtl/core/rofr_ram.sv
module rofr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/rofr_edge.sv
module rofr_edge #(
    parameter int CW = 27
) (
    input  logic signed [CW-1:0] p,
    input  logic signed [CW-1:0] lo,
    input  logic signed [CW-1:0] hi,
    input  logic signed [CW-1:0] blo,
    input  logic signed [CW-1:0] bhi,
    output rofr_pkg::hit_t       hit
);

    // inside the span, and within one unit of either end
    assign hit.in_span = (p >= lo) && (p <= hi);
    assign hit.border  = (p < blo) || (p > bhi);

endmodule

### rtl/core/rect_outline_fill_raster.sv
// channel  | dir | handshake          | payload
// s_       | in  | s_tvalid/s_tready  | s_tuser: func; s_tdata: command fields
// m_       | out | m_tvalid/m_tready  | m_tdata: status, pixel
// cfg_     | in  | cfg_we             | cfg_addr, cfg_wdata
//
// draw: S_SETUP steps, then the row/column sweep, then S_DONE loads the result
// clear: sweep writing bg_char, then S_DONE; read: S_READ then S_DONE; others go to S_DONE
// the sweep visits one pixel per cycle within a row through the single frame ram write port
// one item at a time: s_tready is high only while idle; a held result stalls completion
// reset is synchronous; the frame ram has no reset and holds garbage until cleared or drawn
`include "rect_outline_fill_raster_defines.svh"

module rect_outline_fill_raster #(
    parameter int MAX_DIM   = 256,
    parameter int FRAC_BITS = 8
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // filled, rect_x, rect_y, rect_w, rect_h, color, read_col, read_row
    input  logic [rofr_pkg::IN_TDATA_W-1:0]     s_tdata,
    // func
    input  logic [1:0]                          s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // status, pixel
    output logic [rofr_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                                cfg_we,
    input  logic [rofr_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [rofr_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int DIM_BITS = $clog2(MAX_DIM);
    localparam int AW       = 2 * DIM_BITS;
    localparam int CW       = (DIM_BITS + FRAC_BITS + 2 > 27) ? DIM_BITS + FRAC_BITS + 2 : 27;
    localparam logic signed [CW-1:0] ONE = CW'(64'd1 << FRAC_BITS);
    localparam logic [10:0] MAX_DIM_EXT  = 11'(MAX_DIM);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SETUP = 3'd1;
    localparam logic [2:0] S_ROW   = 3'd2;
    localparam logic [2:0] S_COL   = 3'd3;
    localparam logic [2:0] S_READ  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    // configuration
    logic [rofr_pkg::CFG_DATA_W-1:0] frame_width_reg, frame_height_reg;
    logic [rofr_pkg::CHAR_W-1:0]     bg_char_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= rofr_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= rofr_pkg::FRAME_HEIGHT_RST;
            bg_char_reg      <= rofr_pkg::BG_CHAR_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                rofr_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata;
                rofr_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
                rofr_pkg::REG_BG_CHAR:      bg_char_reg      <= cfg_wdata[rofr_pkg::CHAR_W-1:0];
                default: ;
            endcase
        end
    end

    function automatic logic [DIM_BITS-1:0] last_index(input logic [rofr_pkg::CFG_DATA_W-1:0] v);
        logic [10:0] ve;
        ve = {2'b00, v};
        if (ve == 11'd0) begin
            return '0;
        end else if (ve > MAX_DIM_EXT) begin
            return DIM_BITS'(MAX_DIM - 1);
        end else begin
            return DIM_BITS'(ve - 11'd1);
        end
    endfunction

    logic [DIM_BITS-1:0] last_col, last_row;
    assign last_col = last_index(frame_width_reg);
    assign last_row = last_index(frame_height_reg);

    // state and latched command
    logic [2:0]                  state_reg, state_next;
    logic [2:0]                  step_reg, step_next;
    logic [1:0]                  func_reg, func_next;
    logic                        filled_reg, filled_next;
    logic                        rej_reg, rej_next;
    logic [rofr_pkg::CHAR_W-1:0] color_reg, color_next;
    logic [7:0]                  rd_col_reg, rd_col_next, rd_row_reg, rd_row_next;
    logic signed [rofr_pkg::COORD_W-1:0] x_reg, x_next, y_reg, y_next;
    logic signed [rofr_pkg::COORD_W-1:0] w_reg, w_next, h_reg, h_next;
    logic signed [CW-1:0] x2_reg, x2_next, y2_reg, y2_next;
    logic signed [CW-1:0] xbl_reg, xbl_next, ybl_reg, ybl_next;
    logic signed [CW-1:0] xbh_reg, xbh_next, ybh_reg, ybh_next;
    logic [DIM_BITS-1:0]  col_reg, col_next, row_reg, row_next;
    logic                 row_in_reg, row_in_next, row_bd_reg, row_bd_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic                 status_reg, status_next;
    logic [rofr_pkg::CHAR_W-1:0] pixel_reg, pixel_next;

    // shared setup adder
    logic signed [CW-1:0] add_a, add_b, add_sum;
    always_comb begin
        case (step_reg)
            3'd0:    begin add_a = CW'(x_reg);  add_b = CW'(w_reg); end
            3'd1:    begin add_a = CW'(y_reg);  add_b = CW'(h_reg); end
            3'd2:    begin add_a = CW'(x_reg);  add_b = ONE;        end
            3'd3:    begin add_a = CW'(y_reg);  add_b = ONE;        end
            3'd4:    begin add_a = x2_reg;      add_b = -ONE;       end
            default: begin add_a = y2_reg;      add_b = -ONE;       end
        endcase
    end
    assign add_sum = add_a + add_b;

    // shared edge compare, rows in S_ROW and columns in S_COL
    logic signed [CW-1:0] cmp_p, cmp_lo, cmp_hi, cmp_blo, cmp_bhi;
    rofr_pkg::hit_t       hit;
    logic                 row_phase;

    assign row_phase = (state_reg == S_ROW);
    assign cmp_p   = row_phase ? (CW'(row_reg) << FRAC_BITS) : (CW'(col_reg) << FRAC_BITS);
    assign cmp_lo  = row_phase ? CW'(y_reg) : CW'(x_reg);
    assign cmp_hi  = row_phase ? y2_reg  : x2_reg;
    assign cmp_blo = row_phase ? ybl_reg : xbl_reg;
    assign cmp_bhi = row_phase ? ybh_reg : xbh_reg;

    rofr_edge #(.CW(CW)) u_edge (
        .p   (cmp_p),
        .lo  (cmp_lo),
        .hi  (cmp_hi),
        .blo (cmp_blo),
        .bhi (cmp_bhi),
        .hit (hit)
    );

    // frame store
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr, ram_raddr;
    logic [rofr_pkg::CHAR_W-1:0] ram_wdata, ram_rdata;
    logic [15:0]                 rd_col_ext, rd_row_ext;
    logic                        is_clear;

    assign is_clear   = (func_reg == rofr_pkg::FUNC_CLEAR);
    assign rd_col_ext = 16'(rd_col_reg);
    assign rd_row_ext = 16'(rd_row_reg);
    assign ram_raddr  = {rd_row_ext[DIM_BITS-1:0], rd_col_ext[DIM_BITS-1:0]};
    assign ram_waddr  = {row_reg, col_reg};
    assign ram_wdata  = is_clear ? bg_char_reg : color_reg;
    assign ram_we     = (state_reg == S_COL) &&
                        (is_clear || (row_in_reg && hit.in_span &&
                                      (filled_reg || row_bd_reg || hit.border)));

    rofr_ram #(.WIDTH(rofr_pkg::CHAR_W), .DEPTH(1 << AW)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    logic rd_ok;
    assign rd_ok = ({3'b000, rd_col_reg} <= 11'(last_col)) &&
                   ({3'b000, rd_row_reg} <= 11'(last_row));

    logic s_fire;
    assign s_fire = s_tvalid && s_tready;

    always_comb begin
        state_next    = state_reg;
        step_next     = step_reg;
        func_next     = func_reg;
        filled_next   = filled_reg;
        rej_next      = rej_reg;
        color_next    = color_reg;
        rd_col_next   = rd_col_reg;
        rd_row_next   = rd_row_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        w_next        = w_reg;
        h_next        = h_reg;
        x2_next       = x2_reg;
        y2_next       = y2_reg;
        xbl_next      = xbl_reg;
        ybl_next      = ybl_reg;
        xbh_next      = xbh_reg;
        ybh_next      = ybh_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        row_in_next   = row_in_reg;
        row_bd_next   = row_bd_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        status_next   = status_reg;
        pixel_next    = pixel_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    func_next   = s_tuser;
                    filled_next = s_tdata[0];
                    x_next      = s_tdata[24:1];
                    y_next      = s_tdata[48:25];
                    w_next      = s_tdata[72:49];
                    h_next      = s_tdata[96:73];
                    color_next  = s_tdata[104:97];
                    rd_col_next = s_tdata[112:105];
                    rd_row_next = s_tdata[120:113];
                    step_next   = '0;
                    row_next    = '0;
                    col_next    = '0;
                    rej_next    = 1'b0;
                    unique case (s_tuser)
                        rofr_pkg::FUNC_DRAW: begin
                            // non-positive size: sign bit set or all zero
                            if (s_tdata[72] || s_tdata[96] ||
                                s_tdata[72:49] == '0 || s_tdata[96:73] == '0) begin
                                rej_next   = 1'b1;
                                state_next = S_DONE;
                            end else begin
                                state_next = S_SETUP;
                            end
                        end
                        rofr_pkg::FUNC_READ:  state_next = S_READ;
                        rofr_pkg::FUNC_CLEAR: state_next = S_ROW;
                        default:              state_next = S_DONE;
                    endcase
                end
            end
            S_SETUP: begin
                case (step_reg)
                    3'd0:    x2_next  = add_sum;
                    3'd1:    y2_next  = add_sum;
                    3'd2:    xbl_next = add_sum;
                    3'd3:    ybl_next = add_sum;
                    3'd4:    xbh_next = add_sum;
                    default: ybh_next = add_sum;
                endcase
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd5) begin
                    state_next = S_ROW;
                end
            end
            S_ROW: begin
                row_in_next = hit.in_span;
                row_bd_next = hit.border;
                col_next    = '0;
                state_next  = S_COL;
            end
            S_COL: begin
                if (col_reg == last_col) begin
                    if (row_reg == last_row) begin
                        state_next = S_DONE;
                    end else begin
                        row_next   = row_reg + 1'b1;
                        state_next = S_ROW;
                    end
                end else begin
                    col_next = col_reg + 1'b1;
                end
            end
            S_READ: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    status_next   = rej_reg;
                    pixel_next    = (func_reg == rofr_pkg::FUNC_READ && rd_ok) ? ram_rdata : '0;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        step_reg   <= step_next;
        func_reg   <= func_next;
        filled_reg <= filled_next;
        rej_reg    <= rej_next;
        color_reg  <= color_next;
        rd_col_reg <= rd_col_next;
        rd_row_reg <= rd_row_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        w_reg      <= w_next;
        h_reg      <= h_next;
        x2_reg     <= x2_next;
        y2_reg     <= y2_next;
        xbl_reg    <= xbl_next;
        ybl_reg    <= ybl_next;
        xbh_reg    <= xbh_next;
        ybh_reg    <= ybh_next;
        col_reg    <= col_next;
        row_reg    <= row_next;
        row_in_reg <= row_in_next;
        row_bd_reg <= row_bd_next;
        status_reg <= status_next;
        pixel_reg  <= pixel_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(rofr_pkg::OUT_TDATA_W - rofr_pkg::CHAR_W - 1){1'b0}},
                       pixel_reg, status_reg};

    `ROFR_ASSERT(a_no_write_idle, aclk, aresetn, s_tready |-> !ram_we, "frame write while idle")
    `ROFR_ASSERT(a_busy_after_accept, aclk, aresetn, s_tvalid && s_tready |=> !s_tready, "accepted item did not start work")
    `ROFR_ASSERT(a_write_in_frame, aclk, aresetn, ram_we |-> (col_reg <= last_col && row_reg <= last_row), "write outside active frame")
    `ROFR_ASSERT(a_result_from_done, aclk, aresetn, $rose(m_tvalid) |-> $past(state_reg == S_DONE), "result without finished item")
    `ROFR_ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_tvalid, "result valid after reset")

endmodule
